FILE: hdl/fat12_cluster_chain_walker_unit_defines.svh
// Assertion helpers shared by the cluster chain walker.
// Each check is sampled on the rising clock edge and is off while reset is held.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_UNIT_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define FCCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fccw_pkg.sv
`timescale 1ns / 1ps

package fccw_pkg;

    // Widths of the table address and of one packed table entry
    localparam int ADDR_W       = 13;
    localparam int ENTRY_W      = 12;
    localparam int CFG_IDX_W    = 1;
    localparam int SECTOR_SHIFT = 9;

    localparam int TABLE_BYTES_DEF = 8192;

    // Entries at or above this value mark the end of a chain
    localparam logic [ENTRY_W-1:0] CHAIN_END = 12'hFF8;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_START   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_EMITTED     = 3'd0,
        ST_END_CHAIN   = 3'd1,
        ST_FREE_ENTRY  = 3'd2,
        ST_LIMIT       = 3'd3,
        ST_WRITTEN     = 3'd4,
        ST_NOT_STARTED = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_START  = 1'd0,
        CFG_SECTORS_PER = 1'd1
    } cfg_index_t;

    // Table write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } table_wr_t;

    // Table entry read request
    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] cluster;
    } table_rd_t;

endpackage

FILE: hdl/fccw_table.sv
`timescale 1ns / 1ps

module fccw_table #(
    parameter int TABLE_BYTES = fccw_pkg::TABLE_BYTES_DEF
) (
    input  logic                clk,
    input  fccw_pkg::table_wr_t wr,
    input  fccw_pkg::table_rd_t rd,
    output logic [7:0]          lo_byte,
    output logic [7:0]          hi_byte
);

    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int AW         = fccw_pkg::ADDR_W;
    localparam logic [AW:0] BYTE_LIMIT = (AW + 1)'(TABLE_BYTES);

    // Even and odd byte banks, so both bytes of an entry come out in one read
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];

    logic [AW-2:0]      wr_half;
    logic [BANK_AW-1:0] wr_idx;
    logic               wr_ok;

    logic [AW-1:0]      rd_b;
    logic [AW-1:0]      rd_b1;
    logic [AW-2:0]      even_half;
    logic [AW-2:0]      odd_half;
    logic [BANK_AW-1:0] even_idx;
    logic [BANK_AW-1:0] odd_idx;

    logic [7:0] even_q_reg;
    logic [7:0] odd_q_reg;
    logic       b_odd_reg;
    logic       lo_ok_reg;
    logic       hi_ok_reg;

    // Drop writes beyond the store
    assign wr_half = wr.addr[AW-1:1];
    assign wr_idx  = wr_half[BANK_AW-1:0];
    assign wr_ok   = wr.en && ({1'b0, wr.addr} < BYTE_LIMIT);

    // Entry of cluster c starts at byte c + c/2
    assign rd_b      = {1'b0, rd.cluster} + {2'b00, rd.cluster[fccw_pkg::ENTRY_W-1:1]};
    assign rd_b1     = rd_b + AW'(1);
    assign even_half = rd_b1[AW-1:1];
    assign odd_half  = rd_b[AW-1:1];
    assign even_idx  = even_half[BANK_AW-1:0];
    assign odd_idx   = odd_half[BANK_AW-1:0];

    // Write the even bank
    always_ff @(posedge clk)
    begin
        if (wr_ok && !wr.addr[0])
        begin
            even_mem[wr_idx] <= wr.data;
        end
    end

    // Write the odd bank
    always_ff @(posedge clk)
    begin
        if (wr_ok && wr.addr[0])
        begin
            odd_mem[wr_idx] <= wr.data;
        end
    end

    // Read both banks and hold until the next read
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            even_q_reg <= even_mem[even_idx];
            odd_q_reg  <= odd_mem[odd_idx];
            b_odd_reg  <= rd_b[0];
            lo_ok_reg  <= {1'b0, rd_b} < BYTE_LIMIT;
            hi_ok_reg  <= {1'b0, rd_b1} < BYTE_LIMIT;
        end
    end

    // Order the bytes; bytes past the store read as zero
    assign lo_byte = lo_ok_reg ? (b_odd_reg ? odd_q_reg : even_q_reg) : 8'd0;
    assign hi_byte = hi_ok_reg ? (b_odd_reg ? even_q_reg : odd_q_reg) : 8'd0;

endmodule

FILE: hdl/fat12_cluster_chain_walker_unit.sv
`timescale 1ns / 1ps

// FAT12 cluster chain walker.
// Input channel (in_valid / in_stall) takes one word per operation: a table
// byte write, a file start, or a chain advance. Output channel (out_valid /
// out_stall) gives one result word per operation: sector address, cluster,
// status and bytes covered so far.
// Configuration channel (cfg_valid / cfg_ready, always ready) sets the data
// region start sector (index 0) and sectors per cluster (index 1); write it
// only while no operation is in flight.
// An accepted word is held in the word-in-flight registers (an advance also
// reads its entry into the table read registers); its result is registered
// once the output register is free. No new word is taken until then. The
// table is a synchronous memory in two byte banks; an advance reads its entry
// and then updates the current cluster, which the next advance reads from.
// A stalled result holds in the output register; the block then accepts one
// more word and keeps it until the output register frees up.
// Reset clears the walk state (not started) and restores the configuration
// defaults; the table contents are undefined until written.
`include "fat12_cluster_chain_walker_unit_defines.svh"
module fat12_cluster_chain_walker_unit #(
    parameter int TABLE_BYTES = fccw_pkg::TABLE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [fccw_pkg::ADDR_W-1:0]     byte_addr,
    input  logic [7:0]                      byte_value,
    input  logic [fccw_pkg::ENTRY_W-1:0]    start_cluster,
    input  logic [31:0]                     max_bytes,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     sector_addr,
    output logic [fccw_pkg::ENTRY_W-1:0]    cluster_out,
    output logic [2:0]                      status,
    output logic [31:0]                     bytes_so_far,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int EW = fccw_pkg::ENTRY_W;

    fccw_pkg::opcode_t   in_op;
    fccw_pkg::table_wr_t tbl_wr;
    fccw_pkg::table_rd_t tbl_rd;
    logic [7:0]          lo_byte;
    logic [7:0]          hi_byte;
    logic                accept;
    logic                finish;

    // Configuration
    logic [31:0] data_start_reg;
    logic [7:0]  spc_reg;

    // Walk state
    logic [EW-1:0] cur_reg,    cur_next;
    logic [31:0]   count_reg,  count_next;
    logic [31:0]   limit_reg,  limit_next;
    logic          active_reg, active_next;

    // Word in flight
    logic              busy_reg;
    fccw_pkg::opcode_t op_reg;
    logic [EW-1:0]     start_reg;
    logic [31:0]       max_reg;

    // Result register
    logic              out_valid_reg;
    logic [31:0]       sector_reg,  sector_next;
    logic [EW-1:0]     shown_reg,   shown_next;
    fccw_pkg::status_t status_reg,  status_next;

    logic [15:0]   entry_word;
    logic [EW-1:0] entry;
    logic [EW-1:0] sel_cluster;
    logic [31:0]   cluster_diff;
    logic [31:0]   sector_calc;
    logic [31:0]   cluster_bytes;
    logic [32:0]   count_sum;
    logic [31:0]   count_sat;

    assign in_op     = fccw_pkg::opcode_t'(opcode);
    assign accept    = in_valid && !busy_reg;
    assign finish    = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;

    // Table writes land at accept; entry reads issue at accept
    assign tbl_wr.en      = accept && (in_op == fccw_pkg::OP_WRITE);
    assign tbl_wr.addr    = byte_addr;
    assign tbl_wr.data    = byte_value;
    assign tbl_rd.en      = accept && (in_op == fccw_pkg::OP_ADVANCE);
    assign tbl_rd.cluster = cur_reg;

    fccw_table #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .lo_byte (lo_byte),
        .hi_byte (hi_byte)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= 32'd0;
            spc_reg        <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (fccw_pkg::cfg_index_t'(cfg_index))
                fccw_pkg::CFG_DATA_START:  data_start_reg <= cfg_data;
                fccw_pkg::CFG_SECTORS_PER: spc_reg        <= cfg_data[7:0];
            endcase
        end
    end

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            start_reg <= start_cluster;
            max_reg   <= max_bytes;
        end
    end

    // Unpack the 12-bit entry of the current cluster
    assign entry_word = {hi_byte, lo_byte};
    assign entry      = cur_reg[0] ? entry_word[15:4] : entry_word[EW-1:0];

    // Shared sector arithmetic and saturating byte count
    assign sel_cluster   = (op_reg == fccw_pkg::OP_START) ? start_reg : entry;
    assign cluster_diff  = {{(32 - EW){1'b0}}, sel_cluster} - 32'd2;
    assign sector_calc   = data_start_reg + cluster_diff * {24'd0, spc_reg};
    assign cluster_bytes = {24'd0, spc_reg} << fccw_pkg::SECTOR_SHIFT;
    assign count_sum     = {1'b0, count_reg} + {1'b0, cluster_bytes};
    assign count_sat     = count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];

    // Step the walk for the word in flight
    always_comb
    begin
        cur_next    = cur_reg;
        count_next  = count_reg;
        limit_next  = limit_reg;
        active_next = active_reg;
        sector_next = 32'd0;
        shown_next  = cur_reg;
        status_next = fccw_pkg::ST_NOT_STARTED;
        case (op_reg)
            fccw_pkg::OP_WRITE:
            begin
                status_next = fccw_pkg::ST_WRITTEN;
            end
            fccw_pkg::OP_START:
            begin
                cur_next    = start_reg;
                limit_next  = max_reg;
                count_next  = cluster_bytes;
                active_next = 1'b1;
                sector_next = sector_calc;
                shown_next  = start_reg;
                status_next = fccw_pkg::ST_EMITTED;
            end
            fccw_pkg::OP_ADVANCE:
            begin
                if (!active_reg)
                begin
                    status_next = fccw_pkg::ST_NOT_STARTED;
                end
                else if (count_reg >= limit_reg)
                begin
                    status_next = fccw_pkg::ST_LIMIT;
                end
                else if (entry == '0)
                begin
                    shown_next  = '0;
                    status_next = fccw_pkg::ST_FREE_ENTRY;
                end
                else if (entry >= fccw_pkg::CHAIN_END)
                begin
                    shown_next  = entry;
                    status_next = fccw_pkg::ST_END_CHAIN;
                end
                else
                begin
                    cur_next    = entry;
                    count_next  = count_sat;
                    sector_next = sector_calc;
                    shown_next  = entry;
                    status_next = fccw_pkg::ST_EMITTED;
                end
            end
            default:
            begin
                status_next = fccw_pkg::ST_NOT_STARTED;
            end
        endcase
    end

    // Control and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            count_reg     <= 32'd0;
            limit_reg     <= 32'd0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end

            if (finish)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= cur_next;
                count_reg     <= count_next;
                limit_reg     <= limit_next;
                active_reg    <= active_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            sector_reg <= sector_next;
            shown_reg  <= shown_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sector_addr  = sector_reg;
    assign cluster_out  = shown_reg;
    assign status       = status_reg;
    assign bytes_so_far = count_reg;

    // Checks
    `FCCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        in_valid && !in_stall, in_stall, "accepted word did not occupy the block")
    `FCCW_ASSERT_NEXT(a_result_after_busy, clk, rst_n,
        busy_reg && !out_valid_reg, out_valid_reg, "word in flight produced no result")
    `FCCW_ASSERT_SAME(a_sector_zero, clk, rst_n,
        out_valid && (status != fccw_pkg::ST_EMITTED), sector_addr == 32'd0,
        "sector address set without an emitted cluster")

endmodule
